@@ rtl/srtf_pkg.sv @@
// Shared constants, types and tap tables of the 3/5 sinc row resampler.
`default_nettype none
package srtf_pkg;

   localparam int EXTENT    = 7;
   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = COEF_BITS - 2;
   localparam int NTAPS     = 2 * EXTENT + 1;
   localparam int WIN_DEPTH = 31;
   localparam int WIN_IDX_W = 5;
   localparam int PIX_W     = 8;
   localparam int PROD_W    = PIX_W + 1 + COEF_BITS;
   localparam int ACC_W     = PROD_W + $clog2(NTAPS);
   localparam int GROUP     = 4;
   localparam int NGROUP    = (NTAPS + GROUP - 1) / GROUP;
   localparam int POS_W     = 16;
   localparam int CNT_W     = POS_W + 1;
   localparam int SCALE_W   = CNT_W + 2;
   localparam int IDX_W     = CNT_W + 2;
   localparam int PIX_MAX   = 255;

   localparam longint ONE_Q30     = 64'sd1 <<< 30;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef enum logic [1:0] {
      PHASE_COPY,
      PHASE_ONE_THIRD,
      PHASE_TWO_THIRDS
   } phase_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic [NTAPS-1:0][COEF_BITS-1:0] tap_set_type;

   typedef struct packed {
      logic [NTAPS-1:0][PIX_W-1:0] pixels;
      phase_type                   phase;
      logic                        last;
      logic                        tiny;
   } srtf_job_type;

   // shift-subtract quotient, truncated toward zero; used only for the tap tables
   function automatic longint div_trunc(longint num, longint den);
      logic [63:0] n_mag, d_mag, rem, quo;
      bit          neg;
      neg   = (num < 0) != (den < 0);
      n_mag = (num < 0) ? -num : num;
      d_mag = (den < 0) ? -den : den;
      rem   = '0;
      quo   = '0;
      for (int bit_i = 63; bit_i >= 0; bit_i--) begin
         rem = {rem[62:0], n_mag[bit_i]};
         quo = {quo[62:0], 1'b0};
         if (rem >= d_mag) begin
            rem    = rem - d_mag;
            quo[0] = 1'b1;
         end
      end
      return neg ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic longint sin_q30(longint x);
      longint x2, term, sum;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
         term = div_trunc((term * x2) >>> 30, (2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   function automatic longint cos_q30(longint x);
      longint x2, term, sum;
      x2   = (x * x) >>> 30;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int k = 1; k <= 8; k++) begin
         term = div_trunc((term * x2) >>> 30, (2 * k - 1) * (2 * k));
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   // quadrant-reduced sine (want_sin) or cosine of 2*pi*a/b in Q30
   function automatic longint turn(longint a, longint b, bit want_sin);
      longint am, q, r, x, sx, cx, res;
      am = a - div_trunc(a, b) * b;
      if (am < 0) am = am + b;
      q  = div_trunc(4 * am, b);
      r  = 4 * am - q * b;
      x  = div_trunc(HALF_PI_Q30 * r, b);
      sx = sin_q30(x);
      cx = cos_q30(x);
      case (q % 4)
         0: res = want_sin ? sx : cx;
         1: res = want_sin ? cx : -sx;
         2: res = want_sin ? -sx : -cx;
         default: res = want_sin ? -cx : sx;
      endcase
      return res;
   endfunction

   function automatic tap_set_type build_taps(int off);
      longint      s [NTAPS];
      longint      dc, mag, v, lim, n, sv, cv;
      tap_set_type h;
      dc  = 0;
      lim = (64'sd1 <<< (COEF_BITS - 1)) - 1;
      for (int t = 0; t < NTAPS; t++) begin
         n    = 3 * (t - EXTENT) - off;
         sv   = turn(n, 10, 1'b1);
         cv   = turn(n, 5 * NTAPS, 1'b0);
         s[t] = div_trunc(div_trunc(sv * (ONE_Q30 + cv), n), ONE_Q30);
         dc   = dc + s[t];
      end
      if (dc <= 0) dc = 1;
      for (int t = 0; t < NTAPS; t++) begin
         mag = (s[t] < 0) ? -s[t] : s[t];
         v   = div_trunc((mag <<< (FRAC_BITS + 1)) + dc, 2 * dc);
         if (s[t] < 0) v = -v;
         if (v > lim) v = lim;
         if (v < -lim - 1) v = -lim - 1;
         h[t] = v[COEF_BITS-1:0];
      end
      return h;
   endfunction

   function automatic tap_set_type unit_taps();
      tap_set_type h;
      h = '0;
      h[EXTENT] = COEF_BITS'(64'sd1 <<< FRAC_BITS);
      return h;
   endfunction

   localparam tap_set_type TAPS_COPY = unit_taps();
   localparam tap_set_type TAPS_ONE  = build_taps(5);
   localparam tap_set_type TAPS_TWO  = build_taps(10);

endpackage
`default_nettype wire

@@ rtl/srtf_ifs.sv @@
// Valid/ready channel interfaces for pixel requests and resampled responses.
`default_nettype none
interface srtf_req_if;
   logic                       valid;
   logic                       ready;
   logic [srtf_pkg::PIX_W-1:0] sample;
   logic                       row_end;
   modport source (output valid, output sample, output row_end, input ready);
   modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface srtf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [srtf_pkg::PIX_W-1:0] pixel;
   logic                       row_last;
   logic                       row_too_short;
   modport source (output valid, output pixel, output row_last, output row_too_short,
                   input ready);
   modport sink (input valid, input pixel, input row_last, input row_too_short,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/srtf_filter.sv @@
// Multiply, sum, round and clamp pipeline that turns a gathered tap set into one pixel.
`default_nettype none
module srtf_filter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire srtf_pkg::srtf_job_type job,
   output logic                        advance,
   srtf_rsp_if.source                  rsp
);
   import srtf_pkg::*;

   tap_set_type               taps;
   logic signed [PROD_W-1:0]  prod_in [NTAPS];
   logic signed [PROD_W-1:0]  prod_ff [NTAPS];
   logic                      m_valid_ff, m_last_ff, m_tiny_ff;
   logic signed [ACC_W-1:0]   part_in [NGROUP];
   logic signed [ACC_W-1:0]   part_ff [NGROUP];
   logic                      a_valid_ff, a_last_ff, a_tiny_ff;
   logic signed [ACC_W-1:0]   sum_in;
   logic signed [ACC_W-1:0]   sum_ff;
   logic                      s_valid_ff, s_last_ff, s_tiny_ff;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-1:0]   shifted;
   logic [PIX_W-1:0]          pixel_in;
   logic [PIX_W-1:0]          pixel_ff;
   logic                      out_valid_ff, out_last_ff, out_tiny_ff;

   // stall every stage while the response waits
   assign advance = !out_valid_ff || rsp.ready;

   always_comb begin
      case (job.phase)
         PHASE_COPY:       taps = TAPS_COPY;
         PHASE_ONE_THIRD:  taps = TAPS_ONE;
         PHASE_TWO_THIRDS: taps = TAPS_TWO;
         default:          taps = TAPS_COPY;
      endcase
      for (int t = 0; t < NTAPS; t++) begin
         prod_in[t] = PROD_W'($signed({1'b0, job.pixels[t]}) * $signed(taps[t]));
      end
   end

   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < NTAPS) begin
               part_in[g] = part_in[g] + ACC_W'(prod_ff[g * GROUP + k]);
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NGROUP; g++) begin
         sum_in = sum_in + part_ff[g];
      end
   end

   always_comb begin
      rnd     = sum_ff + (ACC_W'(1) <<< (FRAC_BITS - 1));
      shifted = rnd >>> FRAC_BITS;
      if (s_tiny_ff || rnd < 0) begin
         pixel_in = '0;
      end else if (shifted > ACC_W'(PIX_MAX)) begin
         pixel_in = PIX_W'(PIX_MAX);
      end else begin
         pixel_in = shifted[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff   <= job_valid;
         a_valid_ff   <= m_valid_ff;
         s_valid_ff   <= a_valid_ff;
         out_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff     <= prod_in;
         m_last_ff   <= job.last;
         m_tiny_ff   <= job.tiny;
         part_ff     <= part_in;
         a_last_ff   <= m_last_ff;
         a_tiny_ff   <= m_tiny_ff;
         sum_ff      <= sum_in;
         s_last_ff   <= a_last_ff;
         s_tiny_ff   <= a_tiny_ff;
         pixel_ff    <= pixel_in;
         out_last_ff <= s_last_ff;
         out_tiny_ff <= s_tiny_ff;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel         = pixel_ff;
   assign rsp.row_last      = out_last_ff;
   assign rsp.row_too_short = out_tiny_ff;

endmodule
`default_nettype wire

@@ rtl/sinc_resampler_three_fifths.sv @@
// Top level of the 3/5 windowed-sinc row resampler.
`default_nettype none
// Resamples an image row by 3/5: every 5 input pixels give 3 output pixels,
// output 3k copying input 5k and outputs 3k+1 and 3k+2 filtered by 15-tap
// Hanning-windowed sinc phases (Q2.14 taps), with the row ends mirrored and
// results rounded and clamped to 0..255. Inside a row one pixel transaction
// is accepted every clock; the filter engine issues at most one output per
// clock and a 31-pixel window lets it trail the input by a few pixels, so
// input is held only while the response channel stalls long enough for the
// engine to fall that far behind. After the pixel flagged row_end (or the
// 65536th pixel of a row) input is held while the engine drains the rest of
// the row. Each output leaves through the job register and a multiply,
// two-level add, and round/clamp pipeline after the engine issues it. Rows
// shorter than 8 pixels give ceil(3W/5) zero pixels marked row_too_short.
module sinc_resampler_three_fifths (
   input  wire logic clock,
   input  wire logic reset,
   srtf_req_if.sink   req,
   srtf_rsp_if.source rsp
);
   import srtf_pkg::*;

   logic [PIX_W-1:0]    window_ff [WIN_DEPTH];
   logic [CNT_W-1:0]    count_ff;
   logic [POS_W-1:0]    last_p_ff;
   logic [SCALE_W-1:0]  three_ff;
   logic [CNT_W-1:0]    center_ff;
   phase_type           phase_ff;
   logic [SCALE_W-1:0]  five_next_ff;
   logic                flush_ff;
   logic                tiny_ff;
   logic                job_valid_ff;
   srtf_job_type        job_ff;
   srtf_job_type        job_in;
   logic                advance;
   logic                accept;
   logic                end_eff;
   logic                issue_normal;
   logic                issue_flush;
   logic                issue;
   logic                flush_done;
   logic [CNT_W-1:0]    count_inc;

   // hold input while draining a row or when the window would lose a needed pixel
   assign req.ready = !flush_ff &&
                      ((CNT_W + 1)'(count_ff) + (CNT_W + 1)'(EXTENT) <=
                       (CNT_W + 1)'(center_ff) + (CNT_W + 1)'(WIN_DEPTH - 1));
   assign accept    = req.valid && req.ready;
   assign end_eff   = req.row_end || (count_ff == CNT_W'({POS_W{1'b1}}));
   assign count_inc = count_ff + CNT_W'(1);

   // inside a row: centre plus extent has arrived and the next output exists
   assign issue_normal = !flush_ff &&
                         ((CNT_W + 1)'(center_ff) + (CNT_W + 1)'(EXTENT) <=
                          (CNT_W + 1)'(last_p_ff)) &&
                         (three_ff > five_next_ff);
   // draining: output j exists while 5j < 3W
   assign issue_flush  = flush_ff && (three_ff + SCALE_W'(5) > five_next_ff);
   assign issue        = (issue_normal || issue_flush) && advance;
   assign flush_done   = flush_ff && !issue_flush;

   // gather the tap pixels, mirroring at the row start and, when draining, the row end
   always_comb begin
      logic signed [IDX_W-1:0] i_v;
      logic signed [IDX_W-1:0] d_v;
      logic signed [IDX_W-1:0] p_s;
      p_s = $signed(IDX_W'(last_p_ff));
      for (int t = 0; t < NTAPS; t++) begin
         i_v = $signed(IDX_W'(center_ff)) + IDX_W'(t - EXTENT);
         if (i_v < 0) i_v = IDX_W'(-i_v - IDX_W'(1));
         if (flush_ff && i_v > p_s) i_v = IDX_W'(p_s + p_s + IDX_W'(1) - i_v);
         d_v = IDX_W'(p_s - i_v);
         if (d_v >= 0 && d_v < IDX_W'(WIN_DEPTH)) begin
            job_in.pixels[t] = window_ff[d_v[WIN_IDX_W-1:0]];
         end else begin
            job_in.pixels[t] = '0;
         end
      end
      job_in.phase = phase_ff;
      job_in.last  = flush_ff && (three_ff <= five_next_ff);
      job_in.tiny  = flush_ff && tiny_ff;
   end

   // shift the window on every accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_DEPTH; k++) window_ff[k] <= '0;
      end else if (accept) begin
         window_ff[0] <= req.sample;
         for (int k = 1; k < WIN_DEPTH; k++) window_ff[k] <= window_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_p_ff    <= '0;
         three_ff     <= '0;
         center_ff    <= '0;
         phase_ff     <= PHASE_COPY;
         five_next_ff <= SCALE_W'(5);
         flush_ff     <= 1'b0;
         tiny_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            last_p_ff <= count_ff[POS_W-1:0];
            count_ff  <= count_inc;
            three_ff  <= three_ff + SCALE_W'(3);
            if (end_eff) begin
               flush_ff <= 1'b1;
               tiny_ff  <= count_inc < CNT_W'(EXTENT + 1);
            end
         end
         if (issue) begin
            five_next_ff <= five_next_ff + SCALE_W'(5);
            case (phase_ff)
               PHASE_COPY:       phase_ff <= PHASE_ONE_THIRD;
               PHASE_ONE_THIRD:  phase_ff <= PHASE_TWO_THIRDS;
               default: begin
                  phase_ff  <= PHASE_COPY;
                  center_ff <= center_ff + CNT_W'(5);
               end
            endcase
         end
         // row drained: restart the row counters
         if (flush_done) begin
            flush_ff     <= 1'b0;
            count_ff     <= '0;
            three_ff     <= '0;
            center_ff    <= '0;
            phase_ff     <= PHASE_COPY;
            five_next_ff <= SCALE_W'(5);
         end
         if (advance) job_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) job_ff <= job_in;
   end

   srtf_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid_ff),
      .job       (job_ff),
      .advance   (advance),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

@@ verif/tb_sinc_resampler_three_fifths.sv @@
// Self-checking testbench of the 3/5 windowed-sinc row resampler.
`timescale 1ns / 100ps
`default_nettype none
module tb_sinc_resampler_three_fifths;
   import srtf_pkg::*;

   // Result fields of one resampled pixel, as the block should issue it.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_last;
      logic             row_too_short;
   } out_pix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srtf_req_if req ();
   srtf_rsp_if rsp ();

   sinc_resampler_three_fifths i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #5 clock = ~clock;

   // Predictor state: pixel history (newest first), row position, output count.
   longint   tap_one [NTAPS];
   longint   tap_two [NTAPS];
   logic [PIX_W-1:0] hist [WIN_DEPTH];
   int       row_pos;
   int       out_idx;
   out_pix_type pending_pixels [$];

   int errors;
   int rows_done;
   int pixels_sent;
   int pixels_seen;
   int send_idle_pct;
   int recv_idle_pct;

   // Tap tables: quadrant-reduced Taylor sine and cosine in Q30, integer only.
   function automatic longint q30_sin(longint x);
      longint x2, term, sum;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
         sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
      return sum;
   endfunction

   function automatic longint q30_cos(longint x);
      longint x2, term, sum;
      x2   = (x * x) >>> 30;
      term = 64'sd1 <<< 30;
      sum  = term;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >>> 30) / ((2 * k - 1) * (2 * k));
         sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
      return sum;
   endfunction

   // Sine (pick_sin) or cosine of 2*pi*a/b.
   function automatic longint q30_turn(longint a, longint b, bit pick_sin);
      longint am, q, r, x, sx, cx;
      am = a % b;
      if (am < 0) am = am + b;
      q  = (4 * am) / b;
      r  = 4 * am - q * b;
      x  = (64'sd1686629713 * r) / b;
      sx = q30_sin(x);
      cx = q30_cos(x);
      case (q % 4)
         0: return pick_sin ? sx : cx;
         1: return pick_sin ? cx : -sx;
         2: return pick_sin ? -sx : -cx;
         default: return pick_sin ? -cx : sx;
      endcase
   endfunction

   task automatic make_phase_taps(input int off, output longint h [NTAPS]);
      longint s [NTAPS];
      longint dc, mag, v, lim, n, one;
      one = 64'sd1 <<< 30;
      dc  = 0;
      lim = (64'sd1 <<< (COEF_BITS - 1)) - 1;
      for (int t = 0; t < NTAPS; t++) begin
         n    = 3 * (t - EXTENT) - off;
         s[t] = ((q30_turn(n, 10, 1'b1) * (one + q30_turn(n, 5 * NTAPS, 1'b0))) / n) / one;
         dc   = dc + s[t];
      end
      if (dc <= 0) dc = 1;
      for (int t = 0; t < NTAPS; t++) begin
         mag = (s[t] < 0) ? -s[t] : s[t];
         v   = ((mag <<< (FRAC_BITS + 1)) + dc) / (2 * dc);
         if (s[t] < 0) v = -v;
         if (v > lim) v = lim;
         if (v < -lim - 1) v = -lim - 1;
         h[t] = v;
      end
   endtask

   // Pixel i of the row, mirrored at the start and, when at_end, at the end; p is the newest position.
   function automatic longint row_pixel(int i, int p, bit at_end);
      int d;
      if (i < 0) i = -i - 1;
      if (at_end && i > p) i = 2 * p + 1 - i;
      d = p - i;
      if (d < 0 || d >= WIN_DEPTH) return 0;
      return hist[d];
   endfunction

   function automatic logic [PIX_W-1:0] resampled_value(int p, bit at_end);
      int     c;
      longint acc;
      c = 5 * (out_idx / 3);
      if (out_idx % 3 == 0) return PIX_W'(row_pixel(c, p, at_end));
      acc = 0;
      for (int y = -EXTENT; y <= EXTENT; y++)
         acc += row_pixel(c + y, p, at_end)
                * ((out_idx % 3 == 1) ? tap_one[y + EXTENT] : tap_two[y + EXTENT]);
      acc += 64'sd1 <<< (FRAC_BITS - 1);
      if (acc < 0) return '0;
      acc = acc >>> FRAC_BITS;
      return PIX_W'((acc > PIX_MAX) ? PIX_MAX : acc);
   endfunction

   // Advance the predictor by one accepted pixel and queue the outputs it causes.
   task automatic predict_pixel(input logic [PIX_W-1:0] x, input logic last_in);
      int       p, cnt, total, c;
      bit       at_end, tiny;
      out_pix_type o;
      p   = row_pos;
      cnt = p + 1;
      for (int d = WIN_DEPTH - 1; d > 0; d--) hist[d] = hist[d-1];
      hist[0] = x;
      at_end = last_in || (p == 16'hFFFF);
      if (at_end) begin
         total = (3 * cnt + 4) / 5;
         tiny  = cnt < EXTENT + 1;
         while (out_idx < total) begin
            o.pixel         = tiny ? '0 : resampled_value(p, 1'b1);
            o.row_last      = (out_idx + 1 == total);
            o.row_too_short = tiny;
            pending_pixels.push_back(o);
            out_idx++;
         end
         row_pos = 0;
         out_idx = 0;
         rows_done++;
      end else begin
         forever begin
            c = 5 * (out_idx / 3);
            if (c + EXTENT > p || 3 * cnt <= 5 * (out_idx + 1)) break;
            o.pixel         = resampled_value(p, 1'b0);
            o.row_last      = 1'b0;
            o.row_too_short = 1'b0;
            pending_pixels.push_back(o);
            out_idx++;
         end
         row_pos = cnt & 16'hFFFF;
      end
   endtask

   // Send one pixel transaction; the sender may idle first.
   task automatic send_pixel(input logic [PIX_W-1:0] x, input logic last_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.sample  <= x;
      req.row_end <= last_in;
      do @(posedge clock); while (!req.ready);
      predict_pixel(x, last_in);
      pixels_sent++;
   endtask

   task automatic send_row(input int width, input bit flat, input logic [PIX_W-1:0] level);
      for (int i = 0; i < width; i++)
         send_pixel(flat ? level : PIX_W'($urandom_range(255)), i == width - 1);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Receiver: random stall, then compare each transaction with the oldest expectation.
   always @(posedge clock) begin
      out_pix_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
               $error("unexpected output pixel %0d", rsp.pixel);
               errors++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp.pixel !== want.pixel) begin
                  $error("pixel: expected %0d, got %0d", want.pixel, rsp.pixel);
                  errors++;
               end
               if (rsp.row_last !== want.row_last) begin
                  $error("row_last: expected %0b, got %0b", want.row_last, rsp.row_last);
                  errors++;
               end
               if (rsp.row_too_short !== want.row_too_short) begin
                  $error("row_too_short: expected %0b, got %0b",
                         want.row_too_short, rsp.row_too_short);
                  errors++;
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Directed rows: extremes, edge mirroring, short rows, rows of lengths 1, 7, 8, 9 and 12.
   task automatic test_directed();
      send_row(1, 1'b1, 8'hFF);
      send_row(7, 1'b0, 8'h00);
      send_row(8, 1'b1, 8'h00);
      send_row(9, 1'b1, 8'hFF);
      for (int i = 0; i < 12; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, i == 11);
      wait_drained();
   endtask

   // Random rows of mixed widths, mostly long enough to filter.
   task automatic test_random_rows(input int n_pix);
      int target, w;
      target = pixels_sent + n_pix;
      while (pixels_sent < target) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 40);
         send_row(w, $urandom_range(7) == 0, PIX_W'($urandom_range(255)));
      end
   endtask

   initial begin
      errors = 0; rows_done = 0; pixels_sent = 0; pixels_seen = 0;
      row_pos = 0; out_idx = 0;
      foreach (hist[i]) hist[i] = '0;
      make_phase_taps(5, tap_one);
      make_phase_taps(10, tap_two);
      send_idle_pct = 32;
      recv_idle_pct = 80;
      req.valid   = 1'b0;
      req.sample  = '0;
      req.row_end = 1'b0;
      rsp.ready   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_rows(20);
      // Hold input until everything issued has been received.
      wait_drained();
      send_idle_pct = 80;
      recv_idle_pct = 32;
      test_random_rows(20);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_rows(20);

      wait_drained();
      $display("covered %0d rows, %0d input pixels, %0d output pixels checked",
               rows_done, pixels_sent, pixels_seen);
      $display("short rows, flat and random rows, three idle patterns");
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
